FILE: sv/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg: shared types and constants for the memory requirement calculator
// Field widths, result constants, datapath opcodes, format and sample decode.
// ----------------------------------------------------------------------------
package mrc_pkg;

  localparam int EXTENT_BITS_DEF = 16;
  localparam int SIZE_W          = 64;
  localparam int HALF_W          = 32;
  localparam int FMT_W           = 31;
  localparam int LVL_W           = 5;
  localparam int LAYER_W         = 12;
  localparam int SMP_W           = 7;
  localparam int ALIGN_W         = 13;
  localparam int TYPES_W         = 2;
  localparam int SHIFT_W         = 4;
  localparam int SCALED_W        = SIZE_W + (1 << SHIFT_W);

  localparam logic [ALIGN_W-1:0] BUF_ALIGN = 13'd256;
  localparam logic [ALIGN_W-1:0] IMG_ALIGN = 13'd4096;
  localparam logic [TYPES_W-1:0] BUF_TYPES = 2'b11;
  localparam logic [TYPES_W-1:0] IMG_TYPES = 2'b01;
  localparam logic [SIZE_W-1:0]  BUF_MASK  = 64'hFF;
  localparam logic [SIZE_W-1:0]  IMG_MASK  = 64'hFFF;

  // Per-level size scale: bytes per texel times samples = (mul3 ? 3 : 1) << shift
  typedef struct packed {
    logic               mul3;
    logic [SHIFT_W-1:0] shift;
  } scale_t;

  typedef struct packed {
    logic [FMT_W-1:0] code;
    scale_t           scale;
  } fmt_entry_t;

  localparam scale_t SC_B1  = '{mul3: 1'b0, shift: 4'd0};
  localparam scale_t SC_B2  = '{mul3: 1'b0, shift: 4'd1};
  localparam scale_t SC_B3  = '{mul3: 1'b1, shift: 4'd0};
  localparam scale_t SC_B4  = '{mul3: 1'b0, shift: 4'd2};
  localparam scale_t SC_B8  = '{mul3: 1'b0, shift: 4'd3};
  localparam scale_t SC_B16 = '{mul3: 1'b0, shift: 4'd4};

  // Formats that are not 4 bytes per texel; everything else takes the default
  localparam int FMT_ENTRIES = 22;
  localparam fmt_entry_t FMT_TABLE [FMT_ENTRIES] = '{
    '{31'd9,   SC_B1},  '{31'd10,  SC_B1},  '{31'd13,  SC_B1},  '{31'd14,  SC_B1},
    '{31'd16,  SC_B2},  '{31'd17,  SC_B2},  '{31'd20,  SC_B2},  '{31'd21,  SC_B2},
    '{31'd70,  SC_B2},  '{31'd74,  SC_B2},  '{31'd75,  SC_B2},  '{31'd76,  SC_B2},
    '{31'd23,  SC_B3},  '{31'd29,  SC_B3},  '{31'd30,  SC_B3},  '{31'd36,  SC_B3},
    '{31'd91,  SC_B8},  '{31'd97,  SC_B8},  '{31'd101, SC_B8},  '{31'd103, SC_B8},
    '{31'd107, SC_B16}, '{31'd109, SC_B16}
  };

  function automatic scale_t texel_scale(input logic [FMT_W-1:0] fmt);
    scale_t sc;
    sc = SC_B4;
    for (int i = 0; i < FMT_ENTRIES; i++) begin
      if (fmt == FMT_TABLE[i].code) sc = FMT_TABLE[i].scale;
    end
    return sc;
  endfunction

  // One-hot sample flag to log2; anything else counts as one sample
  function automatic logic [SHIFT_W-1:0] sample_shift(input logic [SMP_W-1:0] s);
    logic [SHIFT_W-1:0] sh;
    sh = '0;
    for (int i = 0; i < SMP_W; i++) begin
      if (s == (SMP_W'(1) << i)) sh = SHIFT_W'(i);
    end
    return sh;
  endfunction

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_BUF_OUT,
    OP_WH,
    OP_DL,
    OP_DH,
    OP_COMB,
    OP_SCALE,
    OP_ACC,
    OP_LL,
    OP_LH,
    OP_LCOMB,
    OP_IMG_OUT
  } mrc_op_t;

  typedef struct packed {
    mrc_op_t op;
  } mrc_cmd_t;

  typedef struct packed {
    logic req_image;
    logic last_level;
  } mrc_sts_t;

endpackage

FILE: sv/mrc_if.sv
// ----------------------------------------------------------------------------
// mrc_in_if / mrc_out_if: request and result channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface mrc_in_if #(
  parameter int EXTENT_BITS = mrc_pkg::EXTENT_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [mrc_pkg::SIZE_W-1:0]    buf_bytes;
  logic [mrc_pkg::FMT_W-1:0]     format_code;
  logic [EXTENT_BITS-1:0]        width;
  logic [EXTENT_BITS-1:0]        height;
  logic [EXTENT_BITS-1:0]        depth;
  logic [mrc_pkg::LVL_W-1:0]     level_cnt;
  logic [mrc_pkg::LAYER_W-1:0]   layer_cnt;
  logic [mrc_pkg::SMP_W-1:0]     samples;

  modport source (
    output valid, cmd, buf_bytes, format_code, width, height, depth,
           level_cnt, layer_cnt, samples,
    input  ready
  );
  modport sink (
    input  valid, cmd, buf_bytes, format_code, width, height, depth,
           level_cnt, layer_cnt, samples,
    output ready
  );
endinterface

interface mrc_out_if;
  logic                          valid;
  logic                          ready;
  logic [mrc_pkg::SIZE_W-1:0]    mem_size;
  logic [mrc_pkg::ALIGN_W-1:0]   mem_alignment;
  logic [mrc_pkg::TYPES_W-1:0]   type_mask;
  logic                          overflow;

  modport source (
    output valid, mem_size, mem_alignment, type_mask, overflow,
    input  ready
  );
  modport sink (
    input  valid, mem_size, mem_alignment, type_mask, overflow,
    output ready
  );
endinterface

FILE: sv/mrc_mul.sv
// ----------------------------------------------------------------------------
// mrc_mul: shared 32x32 multiplier
// Unsigned product with a registered 64-bit result.
// ----------------------------------------------------------------------------
module mrc_mul (
  input  logic                           clk,
  input  logic [mrc_pkg::HALF_W-1:0]     a,
  input  logic [mrc_pkg::HALF_W-1:0]     b,
  output logic [mrc_pkg::SIZE_W-1:0]     p_r
);

  logic [mrc_pkg::SIZE_W-1:0] p_nxt;

  assign p_nxt = mrc_pkg::SIZE_W'(a) * mrc_pkg::SIZE_W'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

FILE: sv/mrc_dp.sv
// ----------------------------------------------------------------------------
// mrc_dp: size datapath
// Request registers, per-level extent shifters, the shared multiplier, the
// scale/round/accumulate logic with sticky overflow, and the result register.
// ----------------------------------------------------------------------------
module mrc_dp #(
  parameter int EXTENT_BITS = mrc_pkg::EXTENT_BITS_DEF
) (
  input  logic                           clk,
  input  mrc_pkg::mrc_cmd_t              cmd,
  output mrc_pkg::mrc_sts_t              sts,
  // request payload
  input  logic                           in_cmd,
  input  logic [mrc_pkg::SIZE_W-1:0]     in_buf_bytes,
  input  logic [mrc_pkg::FMT_W-1:0]      in_format_code,
  input  logic [EXTENT_BITS-1:0]         in_width,
  input  logic [EXTENT_BITS-1:0]         in_height,
  input  logic [EXTENT_BITS-1:0]         in_depth,
  input  logic [mrc_pkg::LVL_W-1:0]      in_level_cnt,
  input  logic [mrc_pkg::LAYER_W-1:0]    in_layer_cnt,
  input  logic [mrc_pkg::SMP_W-1:0]      in_samples,
  // result payload
  output logic [mrc_pkg::SIZE_W-1:0]     out_mem_size,
  output logic [mrc_pkg::ALIGN_W-1:0]    out_mem_alignment,
  output logic [mrc_pkg::TYPES_W-1:0]    out_type_mask,
  output logic                           out_overflow
);

  localparam int SW = mrc_pkg::SIZE_W;
  localparam int HW = mrc_pkg::HALF_W;

  // {carry, v + mask with low bits cleared}
  function automatic logic [SW:0] round_up(input logic [SW-1:0] v,
                                           input logic [SW-1:0] mask);
    logic [SW:0] s;
    s = {1'b0, v} + {1'b0, mask};
    return {s[SW], s[SW-1:0] & ~mask};
  endfunction

  // lo + (hi << 32) with overflow flag in the top bit
  function automatic logic [SW:0] combine(input logic [SW-1:0] lo,
                                          input logic [SW-1:0] hi);
    logic [SW:0] s;
    s = {1'b0, lo} + {1'b0, hi[HW-1:0], {HW{1'b0}}};
    return {s[SW] | (|hi[SW-1:HW]), s[SW-1:0]};
  endfunction

  logic [SW-1:0]                  req_size_r;
  logic                           mul3_r;
  logic [mrc_pkg::SHIFT_W-1:0]    shift_r;
  logic [EXTENT_BITS-1:0]         cur_w_r, cur_h_r, cur_d_r;
  logic [mrc_pkg::LVL_W-1:0]      lvl_left_r;
  logic [mrc_pkg::LAYER_W-1:0]    layers_r;
  logic [SW-1:0]                  prod_r, lo_r, total_r;
  logic                           ov_r;

  logic [HW-1:0]                  w_lv, h_lv, d_lv;
  logic [HW-1:0]                  mul_a, mul_b;
  logic [SW-1:0]                  mul_p;
  logic [SW:0]                    comb_lvl, comb_lay, rnd_lvl, rnd_img, rnd_buf;
  logic [SW:0]                    acc_sum;
  logic [SW+1:0]                  x3;
  logic [mrc_pkg::SCALED_W-1:0]   scaled;
  logic                           scale_ov;
  mrc_pkg::scale_t                in_scale;

  // floor each level extent at one
  assign w_lv = (cur_w_r == '0) ? HW'(1) : HW'(cur_w_r);
  assign h_lv = (cur_h_r == '0) ? HW'(1) : HW'(cur_h_r);
  assign d_lv = (cur_d_r == '0) ? HW'(1) : HW'(cur_d_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      mrc_pkg::OP_WH: begin
        mul_a = w_lv;
        mul_b = h_lv;
      end
      mrc_pkg::OP_DL: begin
        mul_a = mul_p[HW-1:0];
        mul_b = d_lv;
      end
      mrc_pkg::OP_DH: begin
        mul_a = prod_r[SW-1:HW];
        mul_b = d_lv;
      end
      mrc_pkg::OP_LL: begin
        mul_a = total_r[HW-1:0];
        mul_b = HW'(layers_r);
      end
      mrc_pkg::OP_LH: begin
        mul_a = total_r[SW-1:HW];
        mul_b = HW'(layers_r);
      end
      default: ;
    endcase
  end

  mrc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  assign in_scale = mrc_pkg::texel_scale(in_format_code);

  assign comb_lvl = combine(lo_r, mul_p);
  assign comb_lay = combine(lo_r, mul_p);
  assign x3       = mul3_r ? ({2'b00, prod_r} + {1'b0, prod_r, 1'b0}) : {2'b00, prod_r};
  assign scaled   = mrc_pkg::SCALED_W'(x3[SW-1:0]) << shift_r;
  assign scale_ov = (|x3[SW+1:SW]) | (|scaled[mrc_pkg::SCALED_W-1:SW]);
  assign rnd_lvl  = round_up(prod_r, mrc_pkg::IMG_MASK);
  assign acc_sum  = {1'b0, total_r} + {1'b0, rnd_lvl[SW-1:0]};
  assign rnd_img  = round_up(total_r, mrc_pkg::IMG_MASK);
  assign rnd_buf  = round_up(req_size_r, mrc_pkg::BUF_MASK);

  assign sts.req_image  = in_cmd;
  assign sts.last_level = (lvl_left_r == mrc_pkg::LVL_W'(1));

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      mrc_pkg::OP_CAPTURE: begin
        req_size_r <= in_buf_bytes;
        mul3_r     <= in_scale.mul3;
        shift_r    <= in_scale.shift + mrc_pkg::sample_shift(in_samples);
        cur_w_r    <= in_width;
        cur_h_r    <= in_height;
        cur_d_r    <= in_depth;
        lvl_left_r <= (in_level_cnt == '0) ? mrc_pkg::LVL_W'(1) : in_level_cnt;
        layers_r   <= (in_layer_cnt == '0) ? mrc_pkg::LAYER_W'(1) : in_layer_cnt;
        total_r    <= '0;
        ov_r       <= 1'b0;
      end
      mrc_pkg::OP_DL: prod_r <= mul_p;
      mrc_pkg::OP_DH: lo_r <= mul_p;
      mrc_pkg::OP_COMB: begin
        prod_r <= comb_lvl[SW-1:0];
        ov_r   <= ov_r | comb_lvl[SW];
      end
      mrc_pkg::OP_SCALE: begin
        prod_r <= scaled[SW-1:0];
        ov_r   <= ov_r | scale_ov;
      end
      mrc_pkg::OP_ACC: begin
        total_r    <= acc_sum[SW-1:0];
        ov_r       <= ov_r | rnd_lvl[SW] | acc_sum[SW];
        cur_w_r    <= cur_w_r >> 1;
        cur_h_r    <= cur_h_r >> 1;
        cur_d_r    <= cur_d_r >> 1;
        lvl_left_r <= lvl_left_r - mrc_pkg::LVL_W'(1);
      end
      mrc_pkg::OP_LH: lo_r <= mul_p;
      mrc_pkg::OP_LCOMB: begin
        total_r <= comb_lay[SW-1:0];
        ov_r    <= ov_r | comb_lay[SW];
      end
      mrc_pkg::OP_BUF_OUT: begin
        out_mem_size      <= rnd_buf[SW] ? '1 : rnd_buf[SW-1:0];
        out_overflow      <= rnd_buf[SW];
        out_mem_alignment <= mrc_pkg::BUF_ALIGN;
        out_type_mask     <= mrc_pkg::BUF_TYPES;
      end
      mrc_pkg::OP_IMG_OUT: begin
        out_mem_size      <= (ov_r | rnd_img[SW]) ? '1 : rnd_img[SW-1:0];
        out_overflow      <= ov_r | rnd_img[SW];
        out_mem_alignment <= mrc_pkg::IMG_ALIGN;
        out_type_mask     <= mrc_pkg::IMG_TYPES;
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/mrc_ctrl.sv
// ----------------------------------------------------------------------------
// mrc_ctrl: sequencing state machine
// Walks one request through buffer rounding or the per-level image loop and
// the layer multiply, and owns the channel handshakes.
// ----------------------------------------------------------------------------
module mrc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  mrc_pkg::mrc_sts_t    sts,
  output mrc_pkg::mrc_cmd_t    cmd
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_BUF_OUT = 12'b0000_0000_0010,
    S_WH      = 12'b0000_0000_0100,
    S_DL      = 12'b0000_0000_1000,
    S_DH      = 12'b0000_0001_0000,
    S_COMB    = 12'b0000_0010_0000,
    S_SCALE   = 12'b0000_0100_0000,
    S_ACC     = 12'b0000_1000_0000,
    S_LL      = 12'b0001_0000_0000,
    S_LH      = 12'b0010_0000_0000,
    S_LCOMB   = 12'b0100_0000_0000,
    S_IMG_OUT = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   out_load;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = mrc_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = mrc_pkg::OP_CAPTURE;
          state_nxt = sts.req_image ? S_WH : S_BUF_OUT;
        end
      end
      S_BUF_OUT: begin
        if (out_free) begin
          cmd.op    = mrc_pkg::OP_BUF_OUT;
          state_nxt = S_IDLE;
        end
      end
      S_WH: begin
        cmd.op    = mrc_pkg::OP_WH;
        state_nxt = S_DL;
      end
      S_DL: begin
        cmd.op    = mrc_pkg::OP_DL;
        state_nxt = S_DH;
      end
      S_DH: begin
        cmd.op    = mrc_pkg::OP_DH;
        state_nxt = S_COMB;
      end
      S_COMB: begin
        cmd.op    = mrc_pkg::OP_COMB;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.op    = mrc_pkg::OP_SCALE;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op    = mrc_pkg::OP_ACC;
        state_nxt = sts.last_level ? S_LL : S_WH;
      end
      S_LL: begin
        cmd.op    = mrc_pkg::OP_LL;
        state_nxt = S_LH;
      end
      S_LH: begin
        cmd.op    = mrc_pkg::OP_LH;
        state_nxt = S_LCOMB;
      end
      S_LCOMB: begin
        cmd.op    = mrc_pkg::OP_LCOMB;
        state_nxt = S_IMG_OUT;
      end
      S_IMG_OUT: begin
        if (out_free) begin
          cmd.op    = mrc_pkg::OP_IMG_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_load      = (cmd.op == mrc_pkg::OP_BUF_OUT) || (cmd.op == mrc_pkg::OP_IMG_OUT);
  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  // result register is never overwritten while it still holds an untaken result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before transfer");

  // a buffer request goes straight to its output step
  a_buf_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !sts.req_image) |=> (state_r == S_BUF_OUT))
    else $error("buffer request did not go to output step");

  // the last level hands over to the layer multiply
  a_last_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && sts.last_level) |=> (state_r == S_LL))
    else $error("level loop did not end on last level");

  // a result only appears after an output step
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(out_load))
    else $error("result valid without output step");
`endif

endmodule

FILE: sv/memory_requirement_calc_core.sv
// ----------------------------------------------------------------------------
// memory_requirement_calc_core: buffer and image memory requirement calculator
// Rounds buffer sizes to 256 bytes; sums aligned mip level sizes of an image
// times its layer count, saturating on 64-bit overflow.
// ----------------------------------------------------------------------------
//  channel   port      dir  payload
//  request   in_chan   in   cmd, buf_bytes, format_code, width, height,
//                           depth, level_cnt, layer_cnt, samples
//  result    out_chan  out  mem_size, mem_alignment, type_mask, overflow
//
//  Buffer request: captured, then rounded into the output register when free.
//  Image request: each mip level runs WH, DL, DH, COMB, SCALE and ACC through
//  the single shared 32x32 multiplier; then LL, LH, LCOMB and IMG_OUT follow.
//  A new request is taken the cycle after a result enters the output register.
//  A result waiting on out_chan.ready stalls only the final output step.
//  rst_n is synchronous, active low; it clears the state machine and out valid.
// ----------------------------------------------------------------------------
module memory_requirement_calc_core #(
  parameter int EXTENT_BITS = mrc_pkg::EXTENT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mrc_in_if.sink      in_chan,
  mrc_out_if.source   out_chan
);

  mrc_pkg::mrc_cmd_t cmd;
  mrc_pkg::mrc_sts_t sts;

  mrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mrc_dp #(
    .EXTENT_BITS (EXTENT_BITS)
  ) u_dp (
    .clk               (clk),
    .cmd               (cmd),
    .sts               (sts),
    .in_cmd            (in_chan.cmd),
    .in_buf_bytes      (in_chan.buf_bytes),
    .in_format_code    (in_chan.format_code),
    .in_width          (in_chan.width),
    .in_height         (in_chan.height),
    .in_depth          (in_chan.depth),
    .in_level_cnt      (in_chan.level_cnt),
    .in_layer_cnt      (in_chan.layer_cnt),
    .in_samples        (in_chan.samples),
    .out_mem_size      (out_chan.mem_size),
    .out_mem_alignment (out_chan.mem_alignment),
    .out_type_mask     (out_chan.type_mask),
    .out_overflow      (out_chan.overflow)
  );

endmodule

FILE: bench/memory_requirement_calc_core_test.sv
// ----------------------------------------------------------------------------
// memory_requirement_calc_core_test: self-checking bench for the calculator
// Feeds buffer and image requests through the request channel with random
// gaps and result back-pressure, predicts each size/alignment/type/overflow
// result and compares it field by field, in order, with what comes out.
// ----------------------------------------------------------------------------
module memory_requirement_calc_core_test;

  localparam int SIZE_W       = mrc_pkg::SIZE_W;
  localparam int FMT_W        = mrc_pkg::FMT_W;
  localparam int LVL_W        = mrc_pkg::LVL_W;
  localparam int LAYER_W      = mrc_pkg::LAYER_W;
  localparam int SMP_W        = mrc_pkg::SMP_W;
  localparam int ALIGN_W      = mrc_pkg::ALIGN_W;
  localparam int TYPES_W      = mrc_pkg::TYPES_W;

  localparam int EXT_BITS     = mrc_pkg::EXTENT_BITS_DEF;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_REQS  = 400;

  localparam bit REQ_BUFFER = 1'b0;
  localparam bit REQ_IMAGE  = 1'b1;

  // Format codes with a non-default texel size, plus a few 4-byte ones
  localparam int unsigned FMT_POOL [33] = '{
    9, 10, 13, 14, 16, 17, 20, 21, 70, 74, 75, 76, 23, 29, 30, 36,
    37, 43, 44, 50, 98, 99, 100, 77, 81, 82, 83, 91, 97, 101, 103, 107, 109
  };

  typedef struct packed {
    bit                cmd;
    bit [SIZE_W-1:0]   bytes;
    bit [FMT_W-1:0]    fmt;
    bit [EXT_BITS-1:0] w;
    bit [EXT_BITS-1:0] h;
    bit [EXT_BITS-1:0] d;
    bit [LVL_W-1:0]    levels;
    bit [LAYER_W-1:0]  layers;
    bit [SMP_W-1:0]    smp;
  } mem_req_t;

  typedef struct packed {
    bit [SIZE_W-1:0]  bytes;
    bit [ALIGN_W-1:0] align;
    bit [TYPES_W-1:0] types;
    bit               ovf;
  } mem_need_t;

  logic clk;
  logic rst_n;

  mrc_in_if #(.EXTENT_BITS(EXT_BITS)) req_if ();
  mrc_out_if res_if ();

  memory_requirement_calc_core #(.EXTENT_BITS(EXT_BITS)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (res_if)
  );

  mem_req_t  req_queue [$];
  mem_need_t need_queue [$];
  mem_req_t  cur_req;
  mem_need_t want;
  int        req_total;
  int        req_sent;
  int        err_count;
  int        cycle_cnt;
  int        src_gap;
  int        src_burst;
  int        sink_stall;
  int        sink_burst;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic bit [SIZE_W-1:0] clip(input bit [2*SIZE_W-1:0] v, inout bit ovf);
    if (v[2*SIZE_W-1:SIZE_W] != '0) begin
      ovf = 1'b1;
      return '1;
    end
    return v[SIZE_W-1:0];
  endfunction

  function automatic bit [SIZE_W-1:0] mul_sat(input bit [SIZE_W-1:0] a,
                                              input bit [SIZE_W-1:0] b, inout bit ovf);
    bit [2*SIZE_W-1:0] p;
    p = {{SIZE_W{1'b0}}, a} * {{SIZE_W{1'b0}}, b};
    return clip(p, ovf);
  endfunction

  function automatic bit [SIZE_W-1:0] round_to_sat(input bit [SIZE_W-1:0] v,
                                                   input bit [SIZE_W-1:0] m, inout bit ovf);
    bit [2*SIZE_W-1:0] s;
    s = {{SIZE_W{1'b0}}, v} + {{SIZE_W{1'b0}}, m};
    return clip(s, ovf) & ~m;
  endfunction

  function automatic bit [SIZE_W-1:0] add_sat(input bit [SIZE_W-1:0] a,
                                              input bit [SIZE_W-1:0] b, inout bit ovf);
    return clip({{SIZE_W{1'b0}}, a} + {{SIZE_W{1'b0}}, b}, ovf);
  endfunction

  function automatic bit [SIZE_W-1:0] bytes_per_texel(input bit [FMT_W-1:0] fmt);
    case (fmt)
      9, 10, 13, 14:                       return SIZE_W'(1);
      16, 17, 20, 21, 70, 74, 75, 76:      return SIZE_W'(2);
      23, 29, 30, 36:                      return SIZE_W'(3);
      91, 97, 101, 103:                    return SIZE_W'(8);
      107, 109:                            return SIZE_W'(16);
      default:                             return SIZE_W'(4);
    endcase
  endfunction

  function automatic bit [SIZE_W-1:0] sample_factor(input bit [SMP_W-1:0] s);
    case (s)
      1, 2, 4, 8, 16, 32, 64: return SIZE_W'(s);
      default:                return SIZE_W'(1);
    endcase
  endfunction

  function automatic bit [SIZE_W-1:0] mip_dim(input bit [EXT_BITS-1:0] v, input int lv);
    bit [EXT_BITS-1:0] e;
    e = v >> lv;
    return (e == '0) ? SIZE_W'(1) : SIZE_W'(e);
  endfunction

  function automatic mem_need_t calc_requirement(input mem_req_t r);
    mem_need_t        n;
    bit               ovf;
    bit [SIZE_W-1:0]  total;
    bit [SIZE_W-1:0]  lvl;
    int               nlev;
    int               nlay;
    ovf = 1'b0;
    if (r.cmd == REQ_BUFFER) begin
      n.bytes = round_to_sat(r.bytes, mrc_pkg::BUF_MASK, ovf);
      n.align = mrc_pkg::BUF_ALIGN;
      n.types = mrc_pkg::BUF_TYPES;
    end else begin
      nlev  = (r.levels == '0) ? 1 : int'(r.levels);
      nlay  = (r.layers == '0) ? 1 : int'(r.layers);
      total = '0;
      for (int lv = 0; lv < nlev; lv++) begin
        lvl   = mul_sat(mip_dim(r.w, lv), mip_dim(r.h, lv), ovf);
        lvl   = mul_sat(lvl, mip_dim(r.d, lv), ovf);
        lvl   = mul_sat(lvl, bytes_per_texel(r.fmt), ovf);
        lvl   = mul_sat(lvl, sample_factor(r.smp), ovf);
        lvl   = round_to_sat(lvl, mrc_pkg::IMG_MASK, ovf);
        total = add_sat(total, lvl, ovf);
      end
      total   = mul_sat(total, SIZE_W'(nlay), ovf);
      n.bytes = round_to_sat(total, mrc_pkg::IMG_MASK, ovf);
      n.align = mrc_pkg::IMG_ALIGN;
      n.types = mrc_pkg::IMG_TYPES;
    end
    n.ovf = ovf;
    if (ovf) n.bytes = '1;
    return n;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic bit [SIZE_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic mem_req_t junk_req();
    mem_req_t r;
    r.bytes  = rand64();
    r.fmt    = FMT_W'($urandom);
    r.w      = EXT_BITS'($urandom);
    r.h      = EXT_BITS'($urandom);
    r.d      = EXT_BITS'($urandom);
    r.levels = LVL_W'($urandom);
    r.layers = LAYER_W'($urandom);
    r.smp    = SMP_W'($urandom);
    return r;
  endfunction

  task automatic add_buffer(input bit [SIZE_W-1:0] b);
    mem_req_t r;
    r       = junk_req();
    r.cmd   = REQ_BUFFER;
    r.bytes = b;
    req_queue.push_back(r);
  endtask

  task automatic add_image(input bit [FMT_W-1:0] fmt, input bit [EXT_BITS-1:0] w,
                           input bit [EXT_BITS-1:0] h, input bit [EXT_BITS-1:0] d,
                           input bit [LVL_W-1:0] levels, input bit [LAYER_W-1:0] layers,
                           input bit [SMP_W-1:0] smp);
    mem_req_t r;
    r        = junk_req();
    r.cmd    = REQ_IMAGE;
    r.fmt    = fmt;
    r.w      = w;
    r.h      = h;
    r.d      = d;
    r.levels = levels;
    r.layers = layers;
    r.smp    = smp;
    req_queue.push_back(r);
  endtask

  // Mostly short gaps, a few long ones, and occasional runs with none
  function automatic int next_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = int'($urandom_range(0, 99));
    if (r < 4) begin
      burst = int'($urandom_range(10, 40));
      return 0;
    end
    if (r < 45) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 60));
  endfunction

  function automatic bit [EXT_BITS-1:0] rand_extent();
    case ($urandom_range(0, 3))
      0:       return EXT_BITS'($urandom);
      1:       return EXT_BITS'($urandom_range(0, 3));
      default: return EXT_BITS'($urandom_range(0, 300));
    endcase
  endfunction

  initial begin
    bit [FMT_W-1:0]   fmt;
    bit [SMP_W-1:0]   smp;
    bit [LAYER_W-1:0] layers;

    rst_n                = 1'b0;
    req_if.valid         = 1'b0;
    req_if.cmd           = 1'b0;
    req_if.buf_bytes     = '0;
    req_if.format_code   = '0;
    req_if.width         = '0;
    req_if.height        = '0;
    req_if.depth         = '0;
    req_if.level_cnt     = '0;
    req_if.layer_cnt     = '0;
    req_if.samples       = '0;
    res_if.ready         = 1'b0;
    req_sent   = 0;
    err_count  = 0;
    cycle_cnt  = 0;
    src_gap    = 0;
    src_burst  = 0;
    sink_stall = 0;
    sink_burst = 0;

    // buffer rounding and saturation at the top of the range
    add_buffer(64'd0);
    add_buffer(64'd1);
    add_buffer(64'd256);
    add_buffer(64'd257);
    add_buffer(64'hFFFF_FFFF_FFFF_FF00);
    add_buffer(64'hFFFF_FFFF_FFFF_FF01);
    add_buffer('1);
    // zero extents, levels, layers and an invalid sample flag
    add_image(31'd0, 16'd0, 16'd0, 16'd0, 5'd0, 12'd0, 7'd0);
    // one request per texel size class, and a second 4-byte one with the largest code
    add_image(31'd9,   16'd17, 16'd9, 16'd1, 5'd3, 12'd1, 7'd1);
    add_image(31'd16,  16'd64, 16'd64, 16'd1, 5'd7, 12'd2, 7'd2);
    add_image(31'd23,  16'd100, 16'd50, 16'd3, 5'd4, 12'd1, 7'd4);
    add_image(31'd37,  16'd256, 16'd256, 16'd1, 5'd9, 12'd6, 7'd8);
    add_image(31'd91,  16'd33, 16'd77, 16'd5, 5'd5, 12'd3, 7'd16);
    add_image(31'd107, 16'd128, 16'd1, 16'd1, 5'd8, 12'd1, 7'd32);
    add_image(31'h7FFF_FFFF, 16'd5, 16'd5, 16'd5, 5'd2, 12'd1, 7'd64);
    // invalid sample flags
    add_image(31'd44, 16'd300, 16'd200, 16'd1, 5'd1, 12'd1, 7'd3);
    add_image(31'd44, 16'd300, 16'd200, 16'd1, 5'd1, 12'd1, 7'd127);
    // largest extents: fits with one level, saturates with many layers
    add_image(31'd107, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd1, 12'd1, 7'd64);
    add_image(31'd107, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, 12'hFFF, 7'd64);
    add_image(31'd109, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, 12'd2048, 7'd64);
    // levels past where every extent has reached one
    add_image(31'd10, 16'd1, 16'd1, 16'd1, 5'd31, 12'd2048, 7'd1);
    add_image(31'd76, 16'hFFFF, 16'd2, 16'd0, 5'd31, 12'hFFF, 7'd0);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      if ($urandom_range(0, 99) < 35) begin
        case ($urandom_range(0, 3))
          0:       add_buffer(rand64());
          1:       add_buffer(~64'd0 - SIZE_W'($urandom_range(0, 600)));
          default: add_buffer(SIZE_W'($urandom_range(0, 100000)));
        endcase
      end else begin
        case ($urandom_range(0, 4))
          0:       fmt = FMT_W'($urandom);
          1:       fmt = FMT_W'($urandom_range(0, 130));
          default: fmt = FMT_W'(FMT_POOL[$urandom_range(0, 32)]);
        endcase
        if ($urandom_range(0, 9) < 7) smp = 7'd1 << $urandom_range(0, 6);
        else smp = SMP_W'($urandom);
        case ($urandom_range(0, 3))
          0:       layers = LAYER_W'($urandom);
          1:       layers = LAYER_W'($urandom_range(2000, 2048));
          default: layers = LAYER_W'($urandom_range(0, 8));
        endcase
        add_image(fmt, rand_extent(), rand_extent(), rand_extent(), LVL_W'($urandom),
                  layers, smp);
      end
    end
    req_total = req_queue.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (req_sent < req_total || need_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("memory_requirement_calc_core_test: clean");
    end else begin
      $display("memory_requirement_calc_core_test: errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        need_queue.push_back(calc_requirement(cur_req));
        req_sent++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (src_gap > 0) begin
          req_if.valid <= 1'b0;
          src_gap--;
        end else if (req_queue.size() != 0) begin
          cur_req = req_queue.pop_front();
          req_if.valid          <= 1'b1;
          req_if.cmd            <= cur_req.cmd;
          req_if.buf_bytes      <= cur_req.bytes;
          req_if.format_code    <= cur_req.fmt;
          req_if.width          <= cur_req.w;
          req_if.height         <= cur_req.h;
          req_if.depth          <= cur_req.d;
          req_if.level_cnt      <= cur_req.levels;
          req_if.layer_cnt      <= cur_req.layers;
          req_if.samples        <= cur_req.smp;
          // gap taken after this transfer
          src_gap = next_gap(src_burst);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (need_queue.size() == 0) begin
          $display("%0t: unexpected result mem_size=%h align=%0d types=%0d overflow=%0b",
                   $time, res_if.mem_size, res_if.mem_alignment, res_if.type_mask,
                   res_if.overflow);
          err_count++;
        end else begin
          want = need_queue.pop_front();
          if (res_if.mem_size !== want.bytes) begin
            $display("%0t: mem_size expected %h actual %h", $time, want.bytes,
                     res_if.mem_size);
            err_count++;
          end
          if (res_if.mem_alignment !== want.align) begin
            $display("%0t: mem_alignment expected %0d actual %0d", $time, want.align,
                     res_if.mem_alignment);
            err_count++;
          end
          if (res_if.type_mask !== want.types) begin
            $display("%0t: type_mask expected %0d actual %0d", $time, want.types,
                     res_if.type_mask);
            err_count++;
          end
          if (res_if.overflow !== want.ovf) begin
            $display("%0t: overflow expected %0b actual %0b", $time, want.ovf,
                     res_if.overflow);
            err_count++;
          end
        end
      end
      if (sink_stall > 0) begin
        res_if.ready <= 1'b0;
        sink_stall--;
      end else begin
        res_if.ready <= 1'b1;
        sink_stall = next_gap(sink_burst);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d of %0d requests sent, %0d results pending", $time,
               req_sent, req_total, need_queue.size());
      $display("memory_requirement_calc_core_test: errors");
      $finish;
    end
  end

endmodule

FILE: files.f
sv/mrc_pkg.sv
sv/mrc_if.sv
sv/mrc_mul.sv
sv/mrc_dp.sv
sv/mrc_ctrl.sv
sv/memory_requirement_calc_core.sv
bench/memory_requirement_calc_core_test.sv
